// File: rtl/deqi_pkg.sv
// Package for the indexed double-ended queue: request and status codes,
// controller states, the command struct to the cell row and the result struct.
// Depends on nothing; every other file of the block imports it.
package deqi_pkg;

  // Field widths of the stream items.
  localparam int unsigned REQ_W   = 2;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned INDEX_W = 8;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned ICOUNT_W = 7;
  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 40;

  // Default sizes of the store.
  localparam int unsigned DEF_DEPTH      = 64;
  localparam int unsigned DEF_DATA_WIDTH = 32;

  // Request codes.
  localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_READ       = 2'd2;

  // Status codes.
  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_RANGE = 2'd2;

  typedef enum logic {
    S_IDLE,
    S_WALK
  } deqi_state_t;

  // Commands broadcast to every cell of the row.
  typedef struct packed {
    logic push_front;
    logic push_back;
    logic load_lanes;
    logic shift_lanes;
  } deqi_cmd_t;

  typedef struct packed {
    logic                empty;
    logic [ICOUNT_W-1:0] count;
    logic [WORD_W-1:0]   data;
    logic [STAT_W-1:0]   status;
  } deqi_res_t;

endpackage

// File: rtl/deqi_cell.sv
// One cell of the queue row: holds one entry and one read-lane word.
// Depends on deqi_pkg for the command struct.
module deqi_cell #(
  parameter int unsigned DATA_WIDTH = deqi_pkg::DEF_DATA_WIDTH,
  parameter int unsigned COUNT_W    = 7,
  parameter int unsigned IDX        = 0
) (
  input  logic                  clk,
  input  deqi_pkg::deqi_cmd_t   cmd,
  input  logic [DATA_WIDTH-1:0] word,
  input  logic [COUNT_W-1:0]    count,
  input  logic [DATA_WIDTH-1:0] prev_entry,
  input  logic [DATA_WIDTH-1:0] next_lane,
  output logic [DATA_WIDTH-1:0] entry,
  output logic [DATA_WIDTH-1:0] lane
);
  import deqi_pkg::*;

  logic at_back;

  // This cell is the first free place behind the last entry.
  assign at_back = (count == COUNT_W'(IDX));

  // Entries move one place back on a push at the front; a push at the back writes the word into the first free cell.
  always_ff @(posedge clk) begin
    if (cmd.push_front) begin
      entry <= prev_entry;
    end else if (cmd.push_back && at_back) begin
      entry <= word;
    end
  end

  // The lane takes a copy of the entries, then shifts towards the front.
  always_ff @(posedge clk) begin
    if (cmd.load_lanes) begin
      lane <= entry;
    end else if (cmd.shift_lanes) begin
      lane <= next_lane;
    end
  end

endmodule

// File: rtl/deqi_chain.sv
// Row of DEPTH queue cells, front entry in cell 0.
// Depends on deqi_pkg and deqi_cell.
module deqi_chain #(
  parameter int unsigned DEPTH      = deqi_pkg::DEF_DEPTH,
  parameter int unsigned DATA_WIDTH = deqi_pkg::DEF_DATA_WIDTH,
  parameter int unsigned COUNT_W    = 7
) (
  input  logic                  clk,
  input  deqi_pkg::deqi_cmd_t   cmd,
  input  logic [DATA_WIDTH-1:0] word,
  input  logic [COUNT_W-1:0]    count,
  output logic [DATA_WIDTH-1:0] lane_head
);
  import deqi_pkg::*;

  logic [DATA_WIDTH-1:0] entry [DEPTH];
  logic [DATA_WIDTH-1:0] lane  [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] prev_entry;
    logic [DATA_WIDTH-1:0] next_lane;

    if (i == 0) begin : g_first
      assign prev_entry = word;
    end else begin : g_inner
      assign prev_entry = entry[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign next_lane = '0;
    end else begin : g_body
      assign next_lane = lane[i+1];
    end

    deqi_cell #(
      .DATA_WIDTH(DATA_WIDTH),
      .COUNT_W   (COUNT_W),
      .IDX       (i)
    ) u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .word      (word),
      .count     (count),
      .prev_entry(prev_entry),
      .next_lane (next_lane),
      .entry     (entry[i]),
      .lane      (lane[i])
    );
  end

  assign lane_head = lane[0];

endmodule

// File: rtl/double_ended_queue_indexed_unit.sv
// Top level of the indexed double-ended queue: stream ports, control and
// result registers. Depends on deqi_pkg and deqi_chain.
//
// Usage. Requests arrive as items on the s_ group: s_tuser carries the request
// kind (push at the front, push at the back, read at an index) and s_tdata the
// word and the index. Every request gives exactly one result item on the m_
// group: the status in m_tuser, the read word, the count after the request
// and an empty flag in m_tdata.
// The entries sit in a row of cells with the front entry in cell 0. A push at
// the front moves every entry one cell back; a push at the back writes the
// cell at the current count. Both finish in the cycle of acceptance and the
// result is registered; pushes are taken one per cycle while s_tready is high.
// A read copies the whole row into a lane of registers, which then shifts one
// cell towards the front per cycle; the word is at cell 0 after index shifts.
// Its result is registered when the walk ends, and the next request is
// accepted only once the lane walk is done. A rejected read (index at or
// beyond the count) or a full push answers as fast as a push.
// Reset (rst, synchronous) empties the queue and drops any pending result;
// the stored words are not cleared. When the receiver stalls, one finished
// result waits in the output register and one more in a holding register;
// s_tready is low while the holding register is taken and during a lane walk.
module double_ended_queue_indexed_unit #(
  parameter int unsigned DEPTH      = deqi_pkg::DEF_DEPTH,
  parameter int unsigned DATA_WIDTH = deqi_pkg::DEF_DATA_WIDTH
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // push_data [31:0], read_index [39:32]
  input  logic [deqi_pkg::IN_DATA_W-1:0]    s_tdata,
  // req_type [1:0]
  input  logic [deqi_pkg::REQ_W-1:0]        s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // read_data [31:0], item_count [38:32], is_empty [39]
  output logic [deqi_pkg::OUT_DATA_W-1:0]   m_tdata,
  // status [1:0]
  output logic [deqi_pkg::STAT_W-1:0]       m_tuser
);
  import deqi_pkg::*;

  localparam int unsigned COUNT_W = $clog2(DEPTH + 1);
  localparam int unsigned CMP_W   = (COUNT_W > INDEX_W) ? COUNT_W : INDEX_W;

  // Request fields.
  logic [REQ_W-1:0]      req_type;
  logic [WORD_W-1:0]     push_data;
  logic [INDEX_W-1:0]    read_index;
  logic [DATA_WIDTH-1:0] word;

  assign req_type   = s_tuser;
  assign push_data  = s_tdata[WORD_W-1:0];
  assign read_index = s_tdata[WORD_W +: INDEX_W];
  assign word       = DATA_WIDTH'(push_data);

  // Control state.
  deqi_state_t          state, state_next;
  logic [COUNT_W-1:0]   count, count_next;
  logic [INDEX_W-1:0]   walk_cnt;
  logic                 accept;
  logic                 full;
  logic                 in_range;

  // Result path.
  deqi_res_t             res, pend, out;
  logic                  res_valid;
  logic                  pend_valid;
  logic                  out_valid;
  logic                  take;
  deqi_cmd_t             cmd;
  logic [DATA_WIDTH-1:0] lane_head;

  assign accept   = s_tvalid && s_tready;
  assign full     = (count == COUNT_W'(DEPTH));
  assign in_range = (CMP_W'(read_index) < CMP_W'(count));
  assign take     = out_valid && m_tready;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && (req_type == REQ_READ) && in_range) begin
          state_next = S_WALK;
        end
      end
      S_WALK: begin
        if (walk_cnt == '0) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Commands to the row, the new count and the result of this cycle.
  always_comb begin
    s_tready   = 1'b0;
    cmd        = '0;
    count_next = count;
    res_valid  = 1'b0;
    res        = '0;
    case (state)
      S_IDLE: begin
        s_tready = !pend_valid;
        if (accept) begin
          res_valid = 1'b1;
          case (req_type)
            REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
              if (full) begin
                res.status = STAT_FULL;
              end else begin
                cmd.push_front = (req_type == REQ_PUSH_FRONT);
                cmd.push_back  = (req_type == REQ_PUSH_BACK);
                count_next     = count + COUNT_W'(1);
              end
            end
            REQ_READ: begin
              if (in_range) begin
                // The answer comes when the lane walk ends.
                cmd.load_lanes = 1'b1;
                res_valid      = 1'b0;
              end else begin
                res.status = STAT_RANGE;
              end
            end
            default: ;
          endcase
        end
      end
      S_WALK: begin
        if (walk_cnt == '0) begin
          res_valid = 1'b1;
          res.data  = WORD_W'(lane_head);
        end else begin
          cmd.shift_lanes = 1'b1;
        end
      end
      default: ;
    endcase
    res.count = ICOUNT_W'(count_next);
    res.empty = (count_next == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  // Lane walk counter: loaded with the index, counted down while shifting.
  always_ff @(posedge clk) begin
    if (cmd.load_lanes) begin
      walk_cnt <= read_index;
    end else if (cmd.shift_lanes) begin
      walk_cnt <= walk_cnt - INDEX_W'(1);
    end
  end

  // Output register with a holding register behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else if (!out_valid || take) begin
      if (pend_valid) begin
        out        <= pend;
        out_valid  <= 1'b1;
        pend_valid <= 1'b0;
      end else begin
        out       <= res;
        out_valid <= res_valid;
      end
    end else if (res_valid) begin
      pend       <= res;
      pend_valid <= 1'b1;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {out.empty, out.count, out.data};
  assign m_tuser  = out.status;

  deqi_chain #(
    .DEPTH     (DEPTH),
    .DATA_WIDTH(DATA_WIDTH),
    .COUNT_W   (COUNT_W)
  ) u_chain (
    .clk      (clk),
    .cmd      (cmd),
    .word     (word),
    .count    (count),
    .lane_head(lane_head)
  );

  // A held result only exists behind a stalled output register.
  a_pend_behind_out: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> out_valid)
    else $error("holding register full while output register empty");

  // No request is taken during a lane walk.
  a_no_accept_walk: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK) |-> !s_tready)
    else $error("request accepted during a lane walk");

  // The count never exceeds the store size.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= COUNT_W'(DEPTH))
    else $error("entry count beyond depth");

  // A push that is not dropped grows the count by one.
  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    (accept && !full && ((req_type == REQ_PUSH_FRONT) || (req_type == REQ_PUSH_BACK)))
    |=> (count == COUNT_W'($past(count) + COUNT_W'(1))))
    else $error("count did not grow after a push");

  // A walk ends with one result.
  a_walk_result: assert property (@(posedge clk) disable iff (rst)
    ((state == S_WALK) && (walk_cnt == '0)) |=> (out_valid && (state == S_IDLE)))
    else $error("lane walk ended without a result");

endmodule

// File: sim/tb.sv
// Self-checking bench for the indexed double-ended queue: sends push and read requests,
// predicts each result from a mirror of the queue and compares every result item.
// Depends on deqi_pkg and double_ended_queue_indexed_unit.
`timescale 1ns / 100ps

module tb;
  import deqi_pkg::*;

  localparam int unsigned QDEPTH = DEF_DEPTH;
  // The fourth request code is not used by the block; it must still answer with one result.
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  // Receiver behaviour: always ready, random stalls, or a fixed stall pattern.
  localparam int READY_ALWAYS  = 0;
  localparam int READY_RANDOM  = 1;
  localparam int READY_PATTERN = 2;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic [REQ_W-1:0]      s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [STAT_W-1:0]     m_tuser;

  // Mirror of the queue as the block should hold it.
  logic [WORD_W-1:0]   mirror_words [QDEPTH];
  logic [5:0]          mirror_head = '0;
  logic [ICOUNT_W-1:0] mirror_count = '0;

  deqi_res_t pending_results [$];

  int  mismatch_count = 0;
  int  results_seen = 0;
  int  burst_left = 0;
  bit  gaps_on = 1'b0;
  int  ready_mode = READY_ALWAYS;
  int  stall_phase = 0;

  double_ended_queue_indexed_unit uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Works out the result of one request and updates the mirror as the block would.
  function automatic deqi_res_t predict_deque_result(input logic [REQ_W-1:0] kind,
                                                     input logic [WORD_W-1:0] word,
                                                     input logic [INDEX_W-1:0] idx);
    deqi_res_t  res;
    logic [5:0] slot;
    res = '0;
    res.status = STAT_OK;
    case (kind)
      REQ_PUSH_FRONT: begin
        if (mirror_count >= QDEPTH) begin
          res.status = STAT_FULL;
        end else begin
          mirror_head = mirror_head - 6'd1;
          mirror_words[mirror_head] = word;
          mirror_count = mirror_count + 1'b1;
        end
      end
      REQ_PUSH_BACK: begin
        if (mirror_count >= QDEPTH) begin
          res.status = STAT_FULL;
        end else begin
          slot = mirror_head + mirror_count[5:0];
          mirror_words[slot] = word;
          mirror_count = mirror_count + 1'b1;
        end
      end
      REQ_READ: begin
        if (idx >= mirror_count) begin
          res.status = STAT_RANGE;
        end else begin
          slot = mirror_head + idx[5:0];
          res.data = mirror_words[slot];
        end
      end
      default: ;
    endcase
    res.count = mirror_count;
    res.empty = (mirror_count == 0);
    return res;
  endfunction

  task automatic report_failure(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("error at %0t ns: %s", $realtime, msg);
    end
  endtask

  // Offers one request and waits for it to be taken. With gaps on, the sender runs in bursts; when a
  // burst ends, tvalid drops for a random gap with junk on the data lines.
  task automatic send_request(input logic [REQ_W-1:0] kind, input logic [WORD_W-1:0] word,
                              input logic [INDEX_W-1:0] idx);
    deqi_res_t expected;
    s_tvalid <= 1'b1;
    s_tdata  <= {idx, word};
    s_tuser  <= kind;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    expected = predict_deque_result(kind, word, idx);
    pending_results.insert(pending_results.size(), expected);
    burst_left--;
    if (gaps_on && burst_left <= 0) begin
      s_tvalid <= 1'b0;
      s_tdata  <= IN_DATA_W'({$urandom, $urandom});
      s_tuser  <= REQ_W'($urandom);
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = $urandom_range(1, 24);
    end
  endtask

  function automatic logic [WORD_W-1:0] pick_word();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return '1;
    if (r < 16) return '0;
    return $urandom;
  endfunction

  // Mostly indexes in range, with the front, the back, the first one past the back and
  // anything up to the top of the field mixed in.
  function automatic logic [INDEX_W-1:0] pick_read_index();
    int r;
    r = $urandom_range(0, 99);
    if (mirror_count == 0 || r >= 90) return INDEX_W'($urandom_range(0, 255));
    if (r < 65) return INDEX_W'($urandom_range(0, mirror_count - 1));
    if (r < 75) return INDEX_W'(mirror_count - 1);
    if (r < 80) return '0;
    return INDEX_W'(mirror_count);
  endfunction

  task automatic send_random_push();
    send_request($urandom_range(0, 1) ? REQ_PUSH_BACK : REQ_PUSH_FRONT, pick_word(),
                 INDEX_W'($urandom_range(0, 255)));
  endtask

  // Receiver stall pattern, independent of the sender.
  always @(posedge clk) begin
    stall_phase <= (stall_phase == 10) ? 0 : stall_phase + 1;
    case (ready_mode)
      READY_RANDOM:  m_tready <= ($urandom_range(0, 99) < 65);
      READY_PATTERN: m_tready <= (stall_phase >= 4);
      default:       m_tready <= 1'b1;
    endcase
  end

  // Every result taken is compared field by field with the oldest prediction.
  always @(posedge clk) begin
    deqi_res_t want;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report_failure($sformatf("result %0d arrived with nothing expected", results_seen));
      end else begin
        want = pending_results.pop_front();
        if (m_tuser !== want.status)
          report_failure($sformatf("result %0d status: expected %0d, got %0d",
                                   results_seen, want.status, m_tuser));
        if (m_tdata[WORD_W-1:0] !== want.data)
          report_failure($sformatf("result %0d read_data: expected %h, got %h",
                                   results_seen, want.data, m_tdata[WORD_W-1:0]));
        if (m_tdata[WORD_W+ICOUNT_W-1:WORD_W] !== want.count)
          report_failure($sformatf("result %0d item_count: expected %0d, got %0d",
                                   results_seen, want.count,
                                   m_tdata[WORD_W+ICOUNT_W-1:WORD_W]));
        if (m_tdata[WORD_W+ICOUNT_W] !== want.empty)
          report_failure($sformatf("result %0d is_empty: expected %0d, got %0d",
                                   results_seen, want.empty, m_tdata[WORD_W+ICOUNT_W]));
      end
    end
  end

  // Empty-queue reads, both push sides with extreme words, front and back reads,
  // the first index past the back and the unused request code.
  task automatic test_directed_cases();
    gaps_on = 1'b0;
    ready_mode = READY_ALWAYS;
    send_request(REQ_READ, '0, 8'd0);
    send_request(REQ_READ, '1, 8'd255);
    send_request(REQ_UNUSED, 32'hDEADBEEF, 8'd0);
    send_request(REQ_PUSH_BACK, 32'hFFFFFFFF, 8'd255);
    send_request(REQ_READ, '0, 8'd0);
    send_request(REQ_PUSH_FRONT, 32'h00000000, 8'd0);
    send_request(REQ_PUSH_FRONT, 32'hA5A5A5A5, 8'hAA);
    send_request(REQ_PUSH_BACK, 32'h5A5A5A5A, 8'h55);
    send_request(REQ_READ, '0, 8'd0);
    send_request(REQ_READ, '0, 8'd1);
    send_request(REQ_READ, '0, 8'd3);
    send_request(REQ_READ, '0, 8'd4);
    send_request(REQ_READ, '0, 8'd128);
    send_request(REQ_UNUSED, '1, 8'd255);
    send_request(REQ_READ, '0, 8'd2);
  endtask

  // The queue grows from a few entries towards full, with many reads at each count.
  task automatic test_growing_queue(input int n_items);
    int r;
    gaps_on = 1'b1;
    ready_mode = READY_RANDOM;
    for (int i = 0; i < n_items; i++) begin
      r = $urandom_range(0, 99);
      if (r < 11) send_random_push();
      else if (r < 98) send_request(REQ_READ, $urandom, pick_read_index());
      else send_request(REQ_UNUSED, $urandom, INDEX_W'($urandom_range(0, 255)));
    end
  endtask

  // Fills the store, then pushes into it while full on both sides and reads its edges.
  task automatic test_full_overflow();
    gaps_on = 1'b1;
    ready_mode = READY_PATTERN;
    while (mirror_count < QDEPTH) send_random_push();
    for (int i = 0; i < 6; i++) send_random_push();
    send_request(REQ_READ, '0, 8'd0);
    send_request(REQ_READ, '0, INDEX_W'(QDEPTH - 1));
    send_request(REQ_READ, '0, INDEX_W'(QDEPTH));
    send_request(REQ_READ, '0, 8'd255);
  endtask

  // Steady traffic on a full store: reads anywhere, dropped pushes, the odd unused code.
  task automatic test_full_store(input int n_items, input bit with_gaps, input int rx_mode);
    int r;
    gaps_on = with_gaps;
    ready_mode = rx_mode;
    for (int i = 0; i < n_items; i++) begin
      r = $urandom_range(0, 99);
      if (r < 15) send_random_push();
      else if (r < 97) send_request(REQ_READ, $urandom, pick_read_index());
      else send_request(REQ_UNUSED, $urandom, INDEX_W'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_directed_cases();
    test_growing_queue(650);
    test_full_overflow();
    test_full_store(300, 1'b0, READY_ALWAYS);
    test_full_store(350, 1'b1, READY_RANDOM);
    test_full_store(150, 1'b1, READY_PATTERN);
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    // Idle time after the last result, longer than the lane walk of the deepest read.
    repeat (100) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog: several times the slowest correct run.
  initial begin
    #15ms;
    $display("FAIL");
    $finish;
  end

endmodule
